>>> hdl/f3x3rb_pkg.sv
// Shared types, constants and helper functions of the 3x3 replicate-border filter.
package f3x3rb_pkg;

  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned COEF_BITS      = 16;
  localparam int unsigned COEF_FRAC      = 14;
  localparam int unsigned MAX_COLS_DEF   = 1024;
  localparam int unsigned MAX_ROWS_DEF   = 1024;
  localparam int unsigned COUNT_BITS     = 11;
  localparam int unsigned KERNEL_BITS    = 3 * COEF_BITS;
  localparam int unsigned POS_OUT_BITS   = 10;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned TDATA_OUT_BITS = 40;
  localparam int unsigned TDATA_PAD_BITS = TDATA_OUT_BITS - SAMPLE_BITS - 2 * POS_OUT_BITS;
  localparam int unsigned CALC_BITS      = 14;

  localparam int unsigned PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned RSUM_BITS = PROD_BITS + 2;
  localparam int unsigned TSUM_BITS = PROD_BITS + 4;
  localparam int unsigned QUOT_BITS = TSUM_BITS - COEF_FRAC;

  localparam logic [COUNT_BITS-1:0]  COUNT_RST = 11'd1024;
  localparam logic [KERNEL_BITS-1:0] KTOP_RST  = '0;
  localparam logic [KERNEL_BITS-1:0] KMID_RST  = 48'h0000_4000_0000;
  localparam logic [KERNEL_BITS-1:0] KBOT_RST  = '0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_COUNT     = 3'd0,
    REG_COL_COUNT     = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MID    = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [RSUM_BITS-1:0]   rsum_t;
  typedef logic signed [TSUM_BITS-1:0]   tsum_t;
  typedef logic signed [QUOT_BITS-1:0]   quot_t;
  typedef logic [2*SAMPLE_BITS-1:0]      line_word_t;  // {older, newer}

  // Which results an item releases.
  typedef struct packed {
    logic has_prev_row;
    logic at_last_row;
    logic has_prev_col;
    logic at_last_col;
  } run_t;

  // Last index of a frame dimension; zero acts as one, above max acts as max.
  function automatic logic [12:0] last_index(logic [COUNT_BITS-1:0] cnt, logic [12:0] maxv);
    logic [12:0] c13;
    c13 = 13'(cnt);
    if (c13 == 13'd0) return 13'd0;
    if (c13 > maxv) return maxv - 13'd1;
    return c13 - 13'd1;
  endfunction

  // Window slot (0 = oldest) holding neighbour pos+k-1, clamped into the frame.
  function automatic logic [1:0] win_sel(logic [CALC_BITS-1:0] pos, logic [1:0] k,
                                         logic [CALC_BITS-1:0] lst,
                                         logic [CALC_BITS-1:0] cur);
    logic signed [CALC_BITS+1:0] t;
    logic signed [CALC_BITS+1:0] u;
    t = $signed({2'b00, pos}) + $signed({14'd0, k}) - 16'sd1;
    if (t < 16'sd0) t = 16'sd0;
    if (t > $signed({2'b00, lst})) t = $signed({2'b00, lst});
    u = t - $signed({2'b00, cur}) + 16'sd2;
    if (u < 16'sd0) u = 16'sd0;
    if (u > 16'sd2) u = 16'sd2;
    return u[1:0];
  endfunction

  function automatic sample_t pick3(logic [1:0] sel, sample_t v0, sample_t v1, sample_t v2);
    case (sel)
      2'd0:    return v0;
      2'd1:    return v1;
      default: return v2;
    endcase
  endfunction

endpackage

>>> hdl/filter3x3_replicate_border.sv
// Streaming 3x3 cross-correlation with replicated frame borders.
//
// Usage:
//  - Samples of a frame enter in raster order on the s_axis channel, one item
//    per handshake. Results leave on m_axis in row-then-column order; tlast
//    marks the final result released by an input item, tuser the saturation.
//  - Registers (frame size, three kernel rows) are written on the cfg channel,
//    which is always ready. Writing a frame size restarts the frame at (0,0);
//    line buffers keep their contents. Write only while the block is idle.
//  - An accepted item passes the line read, window, multiply, row-sum and
//    final-sum registers before its first result is valid.
//  - Throughput: one item per cycle while the receiver is ready. An item
//    releasing several results (up to 4, at the last column or last row)
//    holds the input, as the multiply stage takes one result per cycle.
//  - When the receiver stalls, the result register holds and the stages
//    behind it fill up; the input keeps taking items until every stage is
//    full, then drops tready.
//  - Reset: kernel is the identity, frame 1024x1024 (clipped to the maximum),
//    position (0,0), pipeline empty. No clearing pass: line buffer entries are
//    always written before clamping lets them be read.
module filter3x3_replicate_border #(
  parameter int unsigned MAX_COLS = f3x3rb_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = f3x3rb_pkg::MAX_ROWS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [f3x3rb_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [f3x3rb_pkg::KERNEL_BITS-1:0]      cfg_data_i,
  // Input samples
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [f3x3rb_pkg::SAMPLE_BITS-1:0]      s_axis_tdata,   // sample
  // Results
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // filtered_value [15:0], out_row [25:16], out_col [35:26], zero pad [39:36]
  output logic [f3x3rb_pkg::TDATA_OUT_BITS-1:0]   m_axis_tdata,
  output logic                                    m_axis_tlast,   // last_of_run
  output logic                                    m_axis_tuser    // saturated
);
  import f3x3rb_pkg::*;

  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [12:0] MaxCols13 = 13'(MAX_COLS);
  localparam logic [12:0] MaxRows13 = 13'(MAX_ROWS);
  localparam logic [12:0] RowLastRst = last_index(COUNT_RST, MaxRows13);
  localparam logic [12:0] ColLastRst = last_index(COUNT_RST, MaxCols13);
  localparam tsum_t RoundHalf = TSUM_BITS'(1 << (COEF_FRAC - 1));
  localparam quot_t SatHi = QUOT_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam quot_t SatLo = ~SatHi;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RowW-1:0]        last_row_q;
  logic [ColW-1:0]        last_col_q;
  logic [KERNEL_BITS-1:0] kern_q [3];
  logic [12:0]            row_last_w, col_last_w;
  logic                   cfg_we, cnt_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cnt_wr      = cfg_we && ((cfg_index_i == REG_ROW_COUNT) ||
                                  (cfg_index_i == REG_COL_COUNT));
  assign row_last_w  = last_index(cfg_data_i[COUNT_BITS-1:0], MaxRows13);
  assign col_last_w  = last_index(cfg_data_i[COUNT_BITS-1:0], MaxCols13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q <= RowLastRst[RowW-1:0];
      last_col_q <= ColLastRst[ColW-1:0];
      kern_q[0]  <= KTOP_RST;
      kern_q[1]  <= KMID_RST;
      kern_q[2]  <= KBOT_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_ROW_COUNT:     last_row_q <= row_last_w[RowW-1:0];
        REG_COL_COUNT:     last_col_q <= col_last_w[ColW-1:0];
        REG_KERNEL_TOP:    kern_q[0]  <= cfg_data_i;
        REG_KERNEL_MID:    kern_q[1]  <= cfg_data_i;
        REG_KERNEL_BOTTOM: kern_q[2]  <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake chain: each stage takes a new item when empty or when its
  // current item moves on in the same cycle.
  // ---------------------------------------------------------------------------
  logic v1_q, e_valid_q, m_valid_q, p_valid_q, o_valid_q;
  logic o_rdy, p_rdy, m_rdy;
  logic e_emit, e_last, e_free, s1_adv, in_acc;
  logic e_y_last, e_x_last;

  assign o_rdy  = !o_valid_q || m_axis_tready;
  assign p_rdy  = !p_valid_q || o_rdy;
  assign m_rdy  = !m_valid_q || p_rdy;
  assign e_emit = e_valid_q && m_rdy;
  assign e_free = !e_valid_q || (e_emit && e_last);
  assign s1_adv = v1_q && e_free;

  assign s_axis_tready = !v1_q || e_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Frame position of the next input item
  // ---------------------------------------------------------------------------
  logic [RowW-1:0] row_pos_q;
  logic [ColW-1:0] col_pos_q;
  logic            at_lr_in, at_lc_in;
  run_t            run_in;

  assign at_lr_in = (row_pos_q == last_row_q);
  assign at_lc_in = (col_pos_q == last_col_q);
  assign run_in   = '{has_prev_row: (row_pos_q != '0), at_last_row: at_lr_in,
                      has_prev_col: (col_pos_q != '0), at_last_col: at_lc_in};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else if (cnt_wr) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else if (in_acc) begin
      if (at_lc_in) begin
        col_pos_q <= '0;
        row_pos_q <= at_lr_in ? '0 : row_pos_q + RowW'(1);
      end else begin
        col_pos_q <= col_pos_q + ColW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line buffer read. Both previous rows share one word per column.
  // ---------------------------------------------------------------------------
  line_word_t      line_mem [MAX_COLS];
  line_word_t      rd_q, fwd_data_q, line_w, wr_word;
  sample_t         s1_smp_q;
  logic [RowW-1:0] s1_row_q;
  logic [ColW-1:0] s1_col_q;
  run_t            s1_run_q;
  logic            fwd_q;
  sample_t         line_old, line_new;

  // A one-column frame reads the column written on the same edge.
  assign line_w   = fwd_q ? fwd_data_q : rd_q;
  assign line_old = line_w[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign line_new = line_w[SAMPLE_BITS-1:0];
  assign wr_word  = {line_new, s1_smp_q};

  always_ff @(posedge clk_i) begin
    if (s1_adv) line_mem[s1_col_q] <= wr_word;
    if (in_acc) rd_q <= line_mem[col_pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_smp_q   <= sample_t'(s_axis_tdata);
      s1_row_q   <= row_pos_q;
      s1_col_q   <= col_pos_q;
      s1_run_q   <= run_in;
      fwd_data_q <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_q  <= 1'b1;
        fwd_q <= s1_adv && (s1_col_q == col_pos_q);
      end else if (s1_adv) begin
        v1_q  <= 1'b0;
        fwd_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: 3x3 window and release of up to four results per item
  // ---------------------------------------------------------------------------
  sample_t         win_q [3][3];
  logic [RowW-1:0] e_row_q, e_i;
  logic [ColW-1:0] e_col_q, e_j;
  run_t            e_run_q;
  logic            e_y_q, e_x_q;
  logic            s1_has_out;

  assign s1_has_out = (s1_run_q.has_prev_row || s1_run_q.at_last_row) &&
                      (s1_run_q.has_prev_col || s1_run_q.at_last_col);
  assign e_y_last   = !(e_run_q.has_prev_row && e_run_q.at_last_row) || e_y_q;
  assign e_x_last   = !(e_run_q.has_prev_col && e_run_q.at_last_col) || e_x_q;
  assign e_last     = e_y_last && e_x_last;
  assign e_i = (e_run_q.has_prev_row && !e_y_q) ? e_row_q - RowW'(1) : e_row_q;
  assign e_j = (e_run_q.has_prev_col && !e_x_q) ? e_col_q - ColW'(1) : e_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      e_y_q     <= 1'b0;
      e_x_q     <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          win_q[a][b] <= '0;
        end
      end
    end else if (s1_adv) begin
      e_valid_q <= s1_has_out;
      e_y_q     <= 1'b0;
      e_x_q     <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        win_q[a][0] <= win_q[a][1];
        win_q[a][1] <= win_q[a][2];
      end
      win_q[0][2] <= line_old;
      win_q[1][2] <= line_new;
      win_q[2][2] <= s1_smp_q;
    end else if (e_emit) begin
      if (e_last) begin
        e_valid_q <= 1'b0;
      end else if (e_x_last) begin
        e_x_q <= 1'b0;
        e_y_q <= 1'b1;
      end else begin
        e_x_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      e_row_q <= s1_row_q;
      e_col_q <= s1_col_q;
      e_run_q <= s1_run_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: neighbour selection and nine products
  // ---------------------------------------------------------------------------
  logic [1:0]      sel_r [3];
  logic [1:0]      sel_c [3];
  sample_t         colv  [3][3];
  sample_t         tap   [3][3];
  prod_t           prod_d [3][3];
  prod_t           m_prod_q [3][3];
  logic [RowW-1:0] m_i_q;
  logic [ColW-1:0] m_j_q;
  logic            m_last_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sel_r[k] = win_sel(CALC_BITS'(e_i), 2'(k), CALC_BITS'(last_row_q), CALC_BITS'(e_row_q));
      sel_c[k] = win_sel(CALC_BITS'(e_j), 2'(k), CALC_BITS'(last_col_q), CALC_BITS'(e_col_q));
    end
    for (int a = 0; a < 3; a++) begin
      for (int kj = 0; kj < 3; kj++) begin
        colv[a][kj] = pick3(sel_c[kj], win_q[a][0], win_q[a][1], win_q[a][2]);
      end
    end
    for (int ki = 0; ki < 3; ki++) begin
      for (int kj = 0; kj < 3; kj++) begin
        tap[ki][kj]    = pick3(sel_r[ki], colv[0][kj], colv[1][kj], colv[2][kj]);
        prod_d[ki][kj] = prod_t'(tap[ki][kj]) *
                         prod_t'(coef_t'(kern_q[ki][kj*COEF_BITS +: COEF_BITS]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_rdy) begin
      m_prod_q <= prod_d;
      m_i_q    <= e_i;
      m_j_q    <= e_j;
      m_last_q <= e_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P: kernel row sums
  // ---------------------------------------------------------------------------
  rsum_t           p_sum_q [3];
  logic [RowW-1:0] p_i_q;
  logic [ColW-1:0] p_j_q;
  logic            p_last_q;

  always_ff @(posedge clk_i) begin
    if (p_rdy) begin
      for (int ki = 0; ki < 3; ki++) begin
        p_sum_q[ki] <= rsum_t'(m_prod_q[ki][0]) + rsum_t'(m_prod_q[ki][1]) +
                       rsum_t'(m_prod_q[ki][2]);
      end
      p_i_q    <= m_i_q;
      p_j_q    <= m_j_q;
      p_last_q <= m_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage O: total, round half up, shift to signed Q16.0, saturate
  // ---------------------------------------------------------------------------
  tsum_t                   total;
  quot_t                   quot;
  sample_t                 o_value_d, o_value_q;
  logic                    o_sat_d, o_sat_q;
  logic [POS_OUT_BITS-1:0] o_row_q, o_col_q;
  logic                    o_last_q;

  always_comb begin
    total = tsum_t'(p_sum_q[0]) + tsum_t'(p_sum_q[1]) + tsum_t'(p_sum_q[2]) + RoundHalf;
    quot  = total[TSUM_BITS-1:COEF_FRAC];
    if (quot > SatHi) begin
      o_value_d = SatHi[SAMPLE_BITS-1:0];
      o_sat_d   = 1'b1;
    end else if (quot < SatLo) begin
      o_value_d = SatLo[SAMPLE_BITS-1:0];
      o_sat_d   = 1'b1;
    end else begin
      o_value_d = quot[SAMPLE_BITS-1:0];
      o_sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy) begin
      o_value_q <= o_value_d;
      o_sat_q   <= o_sat_d;
      o_row_q   <= POS_OUT_BITS'(p_i_q);
      o_col_q   <= POS_OUT_BITS'(p_j_q);
      o_last_q  <= p_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (m_rdy) m_valid_q <= e_valid_q;
      if (p_rdy) p_valid_q <= m_valid_q;
      if (o_rdy) o_valid_q <= p_valid_q;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {{TDATA_PAD_BITS{1'b0}}, o_col_q, o_row_q, o_value_q};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_sat_q;

`ifndef SYNTHESIS
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_pos_q <= last_row_q) && (col_pos_q <= last_col_q))
    else $error("position outside frame");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_valid_i && at_lr_in && at_lc_in) |=>
      (row_pos_q == '0) && (col_pos_q == '0))
    else $error("frame did not wrap");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> v1_q)
    else $error("line forward without item in stage 1");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_emit && !e_last) |=> e_valid_q)
    else $error("result run cut short");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_adv) |=> (v1_q && $stable(rd_q) && $stable(s1_col_q)))
    else $error("stalled stage 1 lost its line data");
`endif

endmodule
